// ===== hw/rtl/lat_pkg.sv =====
package lat_pkg;

  // Request and reply kinds
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  // Register indexes on the configuration port (byte address 4*index)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Life rule: survive on two or three neighbors, birth on exactly three
  localparam logic [3:0] SURVIVE_MIN = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_GEN
  } state_t;

endpackage

// ===== hw/rtl/life_automaton_torus_core.sv =====
// Cell write, cell read, unknown request and run of zero generations: done the cycle
//   after accept, next item accepted in that same cycle, so one item per cycle.
// Run of G generations: rows from h on are copied to the other store, then each
//   generation takes one board row per cycle through the single read port of each
//   store; done comes after the last. The run stops early once the board has settled
//   into period two. Reset clears both stores, busy high. Results cannot be stalled.
module life_automaton_torus_core
  import lat_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [5:0]  col,
  input  logic [5:0]  row,
  input  logic        cell_in,
  input  logic [15:0] gen_count,
  // result channel
  output logic        done,
  output logic [1:0]  reply_type,
  output logic        cell_out,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int TW = $clog2(MAX_HEIGHT + 3);
  localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0] board_width;
  logic [6:0] board_height;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(board_height) : 32'(board_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      board_width  <= 7'd64;
      board_height <= 7'd64;
    end else if (cfg_we) begin
      if (paddr[2] == REG_HEIGHT) begin
        board_height <= pwdata[6:0];
      end else begin
        board_width <= pwdata[6:0];
      end
    end
  end

  // Size in use: zero means one, anything above the store means the store size
  logic [WW-1:0] w_used;
  logic [HW-1:0] h_used;
  logic [CW-1:0] wm1;
  logic          h_short;

  always_comb begin
    if (board_width == '0) begin
      w_used = WW'(1);
    end else if (int'(board_width) > MAX_WIDTH) begin
      w_used = WW'(MAX_WIDTH);
    end else begin
      w_used = WW'(board_width);
    end
    if (board_height == '0) begin
      h_used = HW'(1);
    end else if (int'(board_height) > MAX_HEIGHT) begin
      h_used = HW'(MAX_HEIGHT);
    end else begin
      h_used = HW'(board_height);
    end
  end

  assign wm1     = CW'(w_used - WW'(1));
  assign h_short = int'(h_used) < MAX_HEIGHT;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  state_t        state, state_next;
  logic [RW-1:0] rc, rc_next;          // row sweep for clear and copy
  logic [TW-1:0] t, t_next;            // cycle within one generation
  logic [TW-1:0] t_last;
  logic [15:0]   gen_idx, gen_idx_next;
  logic [15:0]   gens_q, gens_q_next;
  logic          sel, sel_next;        // 0: store A is current
  logic          changed, changed_next;
  logic          cp_wv, cp_wv_next;    // copy write pending
  logic [RW-1:0] cp_wa, cp_wa_next;
  logic          done_next;
  logic [1:0]    reply_next;
  logic          rd_pick, rd_pick_next;
  logic [CW-1:0] col_q, col_q_next;

  logic          accept;
  logic          in_store;
  logic          row_diff;
  logic          stop_early;
  logic          last_gen;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_store = (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
  assign t_last   = TW'(h_used) + TW'(2);

  assign stop_early = (gen_idx != '0) && !(changed || row_diff);
  assign last_gen   = (gen_idx == gens_q - 16'd1);

  // Next state and counters
  always_comb begin
    state_next   = state;
    rc_next      = rc;
    t_next       = t;
    gen_idx_next = gen_idx;
    gens_q_next  = gens_q;
    sel_next     = sel;
    changed_next = changed;
    cp_wv_next   = 1'b0;
    cp_wa_next   = cp_wa;
    done_next    = 1'b0;
    reply_next   = reply_type;
    rd_pick_next = 1'b0;
    col_q_next   = col_q;
    case (state)
      ST_CLEAR: begin
        rc_next = rc + RW'(1);
        if (rc == ROW_LAST) begin
          state_next = ST_IDLE;
          rc_next    = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          reply_next = req_type;
          col_q_next = CW'(col);
          if (req_type == REQ_RUN && gen_count != '0) begin
            gens_q_next  = gen_count;
            gen_idx_next = '0;
            t_next       = '0;
            if (h_short) begin
              state_next = ST_COPY;
              rc_next    = RW'(h_used);
            end else begin
              state_next = ST_GEN;
            end
          end else begin
            done_next    = 1'b1;
            rd_pick_next = (req_type == REQ_READ) && in_store;
          end
        end
      end
      ST_COPY: begin
        cp_wv_next = 1'b1;
        cp_wa_next = rc;
        rc_next    = rc + RW'(1);
        if (rc == ROW_LAST) begin
          state_next = ST_GEN;
          rc_next    = '0;
          t_next     = '0;
        end
      end
      ST_GEN: begin
        t_next = t + TW'(1);
        if (t == '0) begin
          changed_next = 1'b0;
        end else if (t >= TW'(3)) begin
          changed_next = changed || row_diff;
        end
        if (t == t_last) begin
          t_next = '0;
          if (stop_early) begin
            // period two from here: the rest of the run flips by parity
            sel_next = sel ^ gens_q[0] ^ gen_idx[0];
          end else begin
            sel_next = ~sel;
          end
          if (stop_early || last_gen) begin
            state_next = ST_IDLE;
            done_next  = 1'b1;
            reply_next = REQ_RUN;
          end else begin
            gen_idx_next = gen_idx + 16'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      rc      <= '0;
      t       <= '0;
      gen_idx <= '0;
      sel     <= 1'b0;
      changed <= 1'b0;
      cp_wv   <= 1'b0;
      done    <= 1'b0;
      rd_pick <= 1'b0;
    end else begin
      state   <= state_next;
      rc      <= rc_next;
      t       <= t_next;
      gen_idx <= gen_idx_next;
      sel     <= sel_next;
      changed <= changed_next;
      cp_wv   <= cp_wv_next;
      done    <= done_next;
      rd_pick <= rd_pick_next;
    end
  end

  always_ff @(posedge clk) begin
    gens_q     <= gens_q_next;
    cp_wa      <= cp_wa_next;
    reply_type <= reply_next;
    col_q      <= col_q_next;
  end

  // ---------------------------------------------------------------------------
  // Board stores: one row of cells per entry, registered read
  // ---------------------------------------------------------------------------
  logic [MAX_WIDTH-1:0] mem_a [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] mem_b [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_a, rd_b;
  logic [MAX_WIDTH-1:0] rd_src, rd_dst;
  logic [MAX_WIDTH-1:0] north, mid;
  logic [MAX_WIDTH-1:0] new_row, col_mask;
  logic [RW-1:0]        addr_a, addr_b;
  logic [RW-1:0]        cur_raddr, oth_raddr, src_addr;
  logic [RW-1:0]        oth_waddr;
  logic [MAX_WIDTH-1:0] oth_wdata;
  logic [RW-1:0]        wr_row;
  logic [CW-1:0]        wr_col;
  logic                 clr_we, cur_we, oth_we, shift;

  // The current store is the source of a generation, the other one its target
  assign rd_src = sel ? rd_b : rd_a;
  assign rd_dst = sel ? rd_a : rd_b;
  assign addr_a = sel ? oth_raddr : cur_raddr;
  assign addr_b = sel ? cur_raddr : oth_raddr;
  assign wr_row = RW'(row);
  assign wr_col = CW'(col);

  // Source rows go north wrap, then 0 .. h-1, then south wrap
  always_comb begin
    if (t == '0) begin
      src_addr = RW'(h_used - HW'(1));
    end else if (t == TW'(h_used) + TW'(1)) begin
      src_addr = '0;
    end else begin
      src_addr = RW'(t - TW'(1));
    end
  end

  // Store control
  always_comb begin
    clr_we    = 1'b0;
    cur_we    = 1'b0;
    oth_we    = cp_wv;
    oth_waddr = cp_wa;
    oth_wdata = rd_src;
    cur_raddr = wr_row;
    oth_raddr = RW'(t - TW'(2));
    shift     = 1'b0;
    case (state)
      ST_CLEAR: clr_we = 1'b1;
      ST_IDLE:  cur_we = accept && (req_type == REQ_WRITE) && in_store;
      ST_COPY:  cur_raddr = rc;
      ST_GEN: begin
        cur_raddr = src_addr;
        shift     = (t != '0);
        // row y is finished when t equals y + 3
        if (!cp_wv && t >= TW'(3)) begin
          oth_we    = 1'b1;
          oth_waddr = RW'(t - TW'(3));
          oth_wdata = new_row;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      mem_a[rc] <= '0;
    end else if (cur_we && !sel) begin
      mem_a[wr_row][wr_col] <= cell_in;
    end else if (oth_we && sel) begin
      mem_a[oth_waddr] <= oth_wdata;
    end
    rd_a <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      mem_b[rc] <= '0;
    end else if (cur_we && sel) begin
      mem_b[wr_row][wr_col] <= cell_in;
    end else if (oth_we && !sel) begin
      mem_b[oth_waddr] <= oth_wdata;
    end
    rd_b <= mem_b[addr_b];
  end

  // Three-row window: north and middle held here, south straight from the store
  always_ff @(posedge clk) begin
    if (shift) begin
      north <= mid;
      mid   <= rd_src;
    end
  end

  // One lane per column: count neighbors with east-west wrap at the active width
  always_comb begin
    int xl;
    int xr;
    logic [3:0] n;
    logic nw, nc, ne, mw, me, sw, sc, se, nv;
    for (int x = 0; x < MAX_WIDTH; x++) begin
      xl = (x == 0) ? 0 : x - 1;
      xr = (x == MAX_WIDTH - 1) ? x : x + 1;
      nw = (x == 0) ? north[wm1] : north[xl];
      mw = (x == 0) ? mid[wm1] : mid[xl];
      sw = (x == 0) ? rd_src[wm1] : rd_src[xl];
      ne = (CW'(x) == wm1) ? north[0] : north[xr];
      me = (CW'(x) == wm1) ? mid[0] : mid[xr];
      se = (CW'(x) == wm1) ? rd_src[0] : rd_src[xr];
      nc = north[x];
      sc = rd_src[x];
      n  = 4'(nw) + 4'(nc) + 4'(ne) + 4'(mw) + 4'(me) + 4'(sw) + 4'(sc) + 4'(se);
      nv = mid[x] ? (n == SURVIVE_MIN || n == BIRTH_COUNT) : (n == BIRTH_COUNT);
      col_mask[x] = (x < int'(w_used));
      // columns beyond the active width keep their value
      new_row[x]  = col_mask[x] ? nv : mid[x];
    end
  end

  assign row_diff = |((new_row ^ rd_dst) & col_mask);

  // Read result comes from the current store's registered read
  assign cell_out = done && rd_pick && (sel ? rd_b[col_q] : rd_a[col_q]);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_source : assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) || $past(state == ST_GEN)))
    else $error("done without an accepted item or a finished run");

  a_cell_read_only : assert property (@(posedge clk) disable iff (rst)
    cell_out |-> (done && reply_type == REQ_READ))
    else $error("cell_out high outside a read result");

  a_gen_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN) |-> (t <= t_last))
    else $error("generation cycle counter past its last row");

  a_busy_rise : assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(accept) && $past(req_type) == REQ_RUN))
    else $error("busy rose without an accepted run");

endmodule

// ===== tb/tb_life_automaton_torus_core.sv =====
`timescale 1ns / 100ps

module tb_life_automaton_torus_core;
  import lat_pkg::*;

  // Board store geometry, matching the block's default parameters
  localparam int BOARD_W = 64;
  localparam int BOARD_H = 64;
  // Request kind with no meaning: the block must echo it and change nothing
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Hard stop on the run, well above the slowest legal run of this stimulus
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  col;
    logic [5:0]  row;
    logic        alive;
    logic [15:0] gens;
  } life_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       alive;
  } life_reply_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [5:0]  col;
  logic [5:0]  row;
  logic        cell_in;
  logic [15:0] gen_count;
  logic        done;
  logic [1:0]  reply_type;
  logic        cell_out;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  life_automaton_torus_core u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .col        (col),
    .row        (row),
    .cell_in    (cell_in),
    .gen_count  (gen_count),
    .done       (done),
    .reply_type (reply_type),
    .cell_out   (cell_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Board predictor: two cell stores, a current-store select and the two size
  // registers. Every accepted item is applied here in acceptance order.
  // ---------------------------------------------------------------------------
  bit          life_store [2][BOARD_W*BOARD_H];
  bit          front_sel;
  logic [6:0]  width_reg  = 7'd64;
  logic [6:0]  height_reg = 7'd64;

  life_req_t   pending_reqs[$];
  life_reply_t expected_replies[$];

  int unsigned mismatches;
  int unsigned replies_checked;
  int unsigned writes_seen, reads_seen, runs_seen, unused_seen;
  longint unsigned gens_asked;
  int unsigned cycle_count;

  // Size actually used: zero means one, anything past the store is clamped
  function automatic int unsigned span_of(logic [6:0] v, int unsigned limit);
    if (v == 7'd0) return 1;
    return (v > limit) ? limit : int'(v);
  endfunction

  // One generation from the current store into the other over the w x h
  // region; report whether any cell of the target store changed.
  function automatic bit evolve_once(int unsigned w, int unsigned h);
    int unsigned yn, ys, xw, xe, n, at;
    bit src, nv, changed;
    changed = 1'b0;
    src = front_sel;
    for (int unsigned y = 0; y < h; y++) begin
      yn = (y == 0) ? h - 1 : y - 1;
      ys = (y + 1 == h) ? 0 : y + 1;
      for (int unsigned x = 0; x < w; x++) begin
        xw = (x == 0) ? w - 1 : x - 1;
        xe = (x + 1 == w) ? 0 : x + 1;
        // count each wrapped neighbor position on its own, even when two
        // positions land on the same cell of a narrow board
        n = life_store[src][yn*BOARD_W + xw] + life_store[src][yn*BOARD_W + x]
          + life_store[src][yn*BOARD_W + xe] + life_store[src][y*BOARD_W + xw]
          + life_store[src][y*BOARD_W + xe]  + life_store[src][ys*BOARD_W + xw]
          + life_store[src][ys*BOARD_W + x]  + life_store[src][ys*BOARD_W + xe];
        at = y*BOARD_W + x;
        nv = life_store[src][at] ? (n == SURVIVE_MIN || n == BIRTH_COUNT)
                                 : (n == BIRTH_COUNT);
        if (life_store[!src][at] != nv) changed = 1'b1;
        life_store[!src][at] = nv;
      end
    end
    return changed;
  endfunction

  function automatic void advance_board(int unsigned gens);
    int unsigned w, h;
    bit changed;
    w = span_of(width_reg, BOARD_W);
    h = span_of(height_reg, BOARD_H);
    if (gens == 0) return;
    // cells outside the active region stay put: mirror them into the scratch
    for (int unsigned y = 0; y < BOARD_H; y++)
      for (int unsigned x = 0; x < BOARD_W; x++)
        if (y >= h || x >= w)
          life_store[!front_sel][y*BOARD_W + x] = life_store[front_sel][y*BOARD_W + x];
    for (int unsigned i = 0; i < gens; i++) begin
      changed = evolve_once(w, h);
      front_sel = !front_sel;
      if (i >= 1 && !changed) begin
        // settled into period two or less: parity of what is left decides
        if (((gens - 1 - i) & 1) != 0) front_sel = !front_sel;
        return;
      end
    end
  endfunction

  function automatic life_reply_t predict_reply(life_req_t req);
    life_reply_t r;
    int unsigned at;
    r.kind  = req.kind;
    r.alive = 1'b0;
    at = int'(req.row) * BOARD_W + int'(req.col);
    case (req.kind)
      REQ_WRITE: begin
        life_store[front_sel][at] = req.alive;
        writes_seen++;
      end
      REQ_READ: begin
        r.alive = life_store[front_sel][at];
        reads_seen++;
      end
      REQ_RUN: begin
        advance_board(req.gens);
        runs_seen++;
        gens_asked += req.gens;
      end
      default: unused_seen++;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: feed items from the pending queue in bursts with random
  // gaps. Predict each item at the edge that accepts it.
  // ---------------------------------------------------------------------------
  life_req_t   drive_req;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : request_driver
    bit go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        expected_replies.push_back(predict_reply(drive_req));
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          drive_req = pending_reqs.pop_front();
          req_type  <= drive_req.kind;
          col       <= drive_req.col;
          row       <= drive_req.row;
          cell_in   <= drive_req.alive;
          gen_count <= drive_req.gens;
          go = 1'b1;
          // count this item against the burst; some bursts run with no gap at all
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      // single assignment per edge: a held start is never dropped and re-raised
      start <= go;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every done cycle carries one result; match it against the
  // oldest prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : reply_monitor
    life_reply_t want;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with no item outstanding", reply_type));
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        if (reply_type !== want.kind)
          report_mismatch($sformatf("reply_type %0d, predicted %0d", reply_type, want.kind));
        if (cell_out !== want.alive)
          report_mismatch($sformatf("cell_out %0b, predicted %0b for kind %0d",
                                    cell_out, want.alive, want.kind));
      end
    end
  end

  // Watchdog: drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("life_automaton_torus_core verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration port and sequencing
  // ---------------------------------------------------------------------------

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_cycle(input logic wr, input logic idx, input logic [31:0] data,
                           output logic [31:0] rd);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_size_reg(input logic idx, input logic [6:0] want);
    logic [31:0] rd;
    apb_cycle(1'b0, idx, 32'd0, rd);
    if (rd !== {25'd0, want})
      report_mismatch($sformatf("size register %0d reads %0h, predicted %0h", idx, rd, want));
  endtask

  task automatic program_size(input logic idx, input logic [6:0] value);
    logic [31:0] rd;
    apb_cycle(1'b1, idx, {25'd0, value}, rd);
    if (idx == REG_WIDTH) width_reg = value;
    else height_reg = value;
    read_size_reg(idx, value);
  endtask

  // Hold until every item is in and answered and the block is quiet
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || start || expected_replies.size() > 0 || busy)
      @(posedge clk);
  endtask

  task automatic queue_req(input logic [1:0] kind, input int unsigned c, input int unsigned r,
                           input logic alive, input logic [15:0] gens);
    life_req_t req;
    req.kind  = kind;
    req.col   = c[5:0];
    req.row   = r[5:0];
    req.alive = alive;
    req.gens  = gens;
    pending_reqs.push_back(req);
  endtask

  // Resize the board once idle, then queue a mix of random items: most often cell
  // writes that seed the active region, reads, and short runs, with some
  // traffic outside the region and some unknown request kinds.
  task automatic play_phase(input logic [6:0] wv, input logic [6:0] hv, input int count);
    life_req_t req;
    int unsigned w, h, pick;
    wait_idle();
    program_size(REG_WIDTH, wv);
    program_size(REG_HEIGHT, hv);
    w = span_of(wv, BOARD_W);
    h = span_of(hv, BOARD_H);
    for (int i = 0; i < count; i++) begin
      pick      = $urandom_range(0, 99);
      req.alive = ($urandom_range(0, 4) < 2);
      req.gens  = 16'd0;
      req.col   = $urandom_range(0, 63);
      req.row   = $urandom_range(0, 63);
      if (pick < 75 && $urandom_range(0, 9) < 8) begin
        req.col = $urandom_range(0, w - 1);
        req.row = $urandom_range(0, h - 1);
      end
      if (pick < 45) begin
        req.kind = REQ_WRITE;
      end else if (pick < 75) begin
        req.kind = REQ_READ;
      end else if (pick < 93) begin
        req.kind = REQ_RUN;
        req.gens = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
      end else begin
        req.kind = REQ_UNUSED;
        req.gens = $urandom_range(0, 16'hFFFF);
      end
      pending_reqs.push_back(req);
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    req_type  = REQ_WRITE;
    col       = 6'd0;
    row       = 6'd0;
    cell_in   = 1'b0;
    gen_count = 16'd0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = 3'd0;
    pwdata    = 32'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // let the clearing pass finish, then confirm the reset board size
    @(posedge clk);
    wait_idle();
    read_size_reg(REG_WIDTH, 7'd64);
    read_size_reg(REG_HEIGHT, 7'd64);

    // Full 64x64 board. Long run on an empty board settles at once.
    queue_req(REQ_RUN, 0, 0, 1'b0, 16'hFFFF);
    queue_req(REQ_WRITE, 0, 0, 1'b1, 16'd0);
    queue_req(REQ_WRITE, 63, 63, 1'b1, 16'd0);
    queue_req(REQ_READ, 0, 0, 1'b0, 16'd0);
    queue_req(REQ_READ, 63, 63, 1'b0, 16'd0);
    queue_req(REQ_READ, 7, 5, 1'b1, 16'd0);
    queue_req(REQ_UNUSED, 63, 63, 1'b1, 16'hFFFF);
    // zero generations leaves the board alone
    queue_req(REQ_RUN, 63, 63, 1'b1, 16'd0);
    queue_req(REQ_READ, 0, 0, 1'b0, 16'd0);
    // the two corners touch only across both wraps: each dies alone
    queue_req(REQ_RUN, 0, 0, 1'b0, 16'd1);
    queue_req(REQ_READ, 63, 63, 1'b0, 16'd0);
    // blinker, run an odd count that settles by parity
    queue_req(REQ_WRITE, 10, 10, 1'b1, 16'd0);
    queue_req(REQ_WRITE, 11, 10, 1'b1, 16'd0);
    queue_req(REQ_WRITE, 12, 10, 1'b1, 16'd0);
    queue_req(REQ_RUN, 0, 0, 1'b0, 16'h8001);
    queue_req(REQ_READ, 11, 9, 1'b0, 16'd0);
    queue_req(REQ_READ, 10, 10, 1'b0, 16'd0);
    queue_req(REQ_WRITE, 11, 9, 1'b0, 16'd0);

    // size registers at zero: a 1x1 torus where the cell is its own neighbor,
    // and a cell outside the region that the run must not touch
    play_phase(7'd0, 7'd0, 0);
    queue_req(REQ_WRITE, 0, 0, 1'b1, 16'd0);
    queue_req(REQ_WRITE, 5, 5, 1'b1, 16'd0);
    queue_req(REQ_RUN, 0, 0, 1'b0, 16'd2);
    queue_req(REQ_READ, 0, 0, 1'b0, 16'd0);
    queue_req(REQ_READ, 5, 5, 1'b0, 16'd0);

    // width two, height past the store (clamped)
    play_phase(7'd2, 7'd127, 0);
    queue_req(REQ_WRITE, 0, 0, 1'b1, 16'd0);
    queue_req(REQ_WRITE, 1, 1, 1'b1, 16'd0);
    queue_req(REQ_RUN, 0, 0, 1'b0, 16'd3);
    queue_req(REQ_READ, 1, 0, 1'b0, 16'd0);

    // random phases across board shapes, small boards first for density
    play_phase(7'd1, 7'd1, 40);
    play_phase(7'd2, 7'd2, 50);
    play_phase(7'd3, 7'd3, 60);
    play_phase(7'd5, 7'd8, 60);
    play_phase(7'd8, 7'd5, 60);
    play_phase(7'd1, 7'd64, 40);
    play_phase(7'd127, 7'd1, 40);
    repeat (3) play_phase($urandom_range(1, 10), $urandom_range(1, 10), 55);
    play_phase(7'd64, 7'd64, 50);
    play_phase($urandom_range(65, 127), $urandom_range(2, 6), 40);

    // drain, then idle on so that a stray result can still show up
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Covered %0d writes, %0d reads, %0d runs (%0d generations asked), %0d unknown kinds",
             writes_seen, reads_seen, runs_seen, gens_asked, unused_seen);
    $display("Checked %0d results on boards from 1x1 to 64x64, size registers 0 to 127",
             replies_checked);
    if (mismatches == 0) begin
      $display("life_automaton_torus_core verification clean");
    end else begin
      $display("life_automaton_torus_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lat_pkg.sv
hw/rtl/life_automaton_torus_core.sv
tb/tb_life_automaton_torus_core.sv
